/* rtl/mbet_pkg.sv */
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared constants, register indexes and helper functions for the
// Mandelbrot escape-time engine.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // Image edge length in pixels; a coordinate index is clamped below it.
  localparam int unsigned IMAGE_SIZE    = 512;
  // Fraction bits of the signed 32-bit coordinate format.
  localparam int unsigned FRACTION_BITS = 28;
  // Shift that turns an exact squared magnitude into whole units.
  localparam int unsigned ESC_SHIFT     = 2 * FRACTION_BITS;

  localparam int unsigned IDX_W   = 9;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned THR_W   = 4;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned MUL_W   = 33;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_X_MIN    = 3'd0,
    CFG_Y_MIN    = 3'd1,
    CFG_X_STEP   = 3'd2,
    CFG_Y_STEP   = 3'd3,
    CFG_MAX_ITER = 3'd4,
    CFG_ESC_THR  = 3'd5
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [COORD_W-1:0] X_MIN_RST    = 32'hE000_0000;
  localparam logic [COORD_W-1:0] Y_MIN_RST    = 32'hE000_0000;
  localparam logic [STEP_W-1:0]  X_STEP_RST   = 31'd2101257;
  localparam logic [STEP_W-1:0]  Y_STEP_RST   = 31'd2101257;
  localparam logic [COUNT_W-1:0] MAX_ITER_RST = 20'd200000;
  localparam logic [THR_W-1:0]   ESC_THR_RST  = 4'd2;

  // Saturate a 64-bit signed value into the 32-bit signed range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = -32'sh8000_0000;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  // Clamp a pixel index to the last row or column of the image.
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (32'(idx) >= IMAGE_SIZE) begin
      res = IDX_W'(IMAGE_SIZE - 1);
    end else begin
      res = idx;
    end
    return res;
  endfunction

endpackage

/* rtl/mandelbrot_escape_time.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration for one pixel at a time, built around a single
// shared signed multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A pixel beat (row, column) maps to c = (x_min + row*x_step) +
// i(y_min + col*y_step) in signed Q4.28 with saturation, and the engine runs
// z = z*z + c from z = c until |z|^2 reaches escape_threshold (whole units)
// or the count reaches max_iterations; the result beat carries the count and
// echoes row and column. All products go through one 33x33 signed multiplier
// with a registered output, so each iteration steps in turn through zr^2,
// zi^2, zr*zi, then the escape test and the update. A new pixel beat is
// taken only once the previous pixel's result has been parked. While a
// pixel is in flight in_stall is high. The finished result sits in an output
// register, so the input is free again as soon as the result is parked
// there, even if the consumer is still stalling. Configuration writes are
// always taken (cfg_ready is tied high) and must only be issued while the
// engine is idle.
module mandelbrot_escape_time
  import mbet_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   in_pixel_row,
  input  logic [IDX_W-1:0]   in_pixel_col,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_iteration_count,
  output logic [IDX_W-1:0]   out_row,
  output logic [IDX_W-1:0]   out_col
);

  // Sequencer states: coordinate setup, then a four-step iteration loop.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CR_MUL,
    S_CI_MUL,
    S_CI_ADD,
    S_RR,
    S_II,
    S_RI,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [COORD_W-1:0] x_min_r, x_min_nxt;
  logic signed [COORD_W-1:0] y_min_r, y_min_nxt;
  logic [STEP_W-1:0]         x_step_r, x_step_nxt;
  logic [STEP_W-1:0]         y_step_r, y_step_nxt;
  logic [COUNT_W-1:0]        max_iter_r, max_iter_nxt;
  logic [THR_W-1:0]          esc_thr_r, esc_thr_nxt;

  // Working registers for the pixel in flight.
  logic [IDX_W-1:0]          row_r, row_nxt;
  logic [IDX_W-1:0]          col_r, col_nxt;
  logic signed [COORD_W-1:0] cr_r, cr_nxt;
  logic signed [COORD_W-1:0] ci_r, ci_nxt;
  logic signed [COORD_W-1:0] zr_r, zr_nxt;
  logic signed [COORD_W-1:0] zi_r, zi_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [PROD_W-1:0]  sqr_r, sqr_nxt;
  logic signed [PROD_W-1:0]  diff_r, diff_nxt;
  logic [PROD_W-1:0]         mag_r, mag_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;

  // Result register.
  logic                      out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic [IDX_W-1:0]          out_row_r, out_row_nxt;
  logic [IDX_W-1:0]          out_col_r, out_col_nxt;

  // Shared multiplier.
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  logic                      in_beat;
  logic                      slot_free;
  logic                      keep_going;
  logic signed [PROD_W-1:0]  nr_wide, ni_wide;

  assign cfg_ready           = 1'b1;
  assign in_stall            = (state_r != S_IDLE);
  assign in_beat             = in_valid && !in_stall;
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_row             = out_row_r;
  assign out_col             = out_col_r;

  // The result slot can take a new value if empty or emptying this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  // Operand selection for the multiplier. Indexes and steps are unsigned and
  // enter with a zero top bit; z components are sign-extended.
  always_comb begin
    unique case (state_r)
      S_CR_MUL: begin
        mul_a = MUL_W'(clamp_idx(row_r));
        mul_b = MUL_W'(x_step_r);
      end
      S_CI_MUL: begin
        mul_a = MUL_W'(clamp_idx(col_r));
        mul_b = MUL_W'(y_step_r);
      end
      S_RR: begin
        mul_a = {zr_r[COORD_W-1], zr_r};
        mul_b = {zr_r[COORD_W-1], zr_r};
      end
      S_II: begin
        mul_a = {zi_r[COORD_W-1], zi_r};
        mul_b = {zi_r[COORD_W-1], zi_r};
      end
      S_RI: begin
        mul_a = {zr_r[COORD_W-1], zr_r};
        mul_b = {zi_r[COORD_W-1], zi_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Escape test: the count is still under the cap and the squared magnitude,
  // in whole units, is still under the threshold.
  assign keep_going = (count_r < max_iter_r) &&
                      ((mag_r >> ESC_SHIFT) < PROD_W'(esc_thr_r));

  // Next z, rounded toward minus infinity; the cross term keeps one more bit
  // because it carries the factor of two.
  assign nr_wide = (diff_r >>> FRACTION_BITS) +
                   $signed({{COORD_W{cr_r[COORD_W-1]}}, cr_r});
  assign ni_wide = (prod_r >>> (FRACTION_BITS - 1)) +
                   $signed({{COORD_W{ci_r[COORD_W-1]}}, ci_r});

  always_comb begin
    state_nxt     = state_r;
    x_min_nxt     = x_min_r;
    y_min_nxt     = y_min_r;
    x_step_nxt    = x_step_r;
    y_step_nxt    = y_step_r;
    max_iter_nxt  = max_iter_r;
    esc_thr_nxt   = esc_thr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    prod_nxt      = mul_p[PROD_W-1:0];
    sqr_nxt       = sqr_r;
    diff_nxt      = diff_r;
    mag_nxt       = mag_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_MIN:    x_min_nxt    = cfg_data;
        CFG_Y_MIN:    y_min_nxt    = cfg_data;
        CFG_X_STEP:   x_step_nxt   = cfg_data[STEP_W-1:0];
        CFG_Y_STEP:   y_step_nxt   = cfg_data[STEP_W-1:0];
        CFG_MAX_ITER: max_iter_nxt = cfg_data[COUNT_W-1:0];
        CFG_ESC_THR:  esc_thr_nxt  = cfg_data[THR_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          row_nxt   = in_pixel_row;
          col_nxt   = in_pixel_col;
          count_nxt = '0;
          state_nxt = S_CR_MUL;
        end
      end
      S_CR_MUL: begin
        state_nxt = S_CI_MUL;
      end
      S_CI_MUL: begin
        // prod_r holds row * x_step.
        cr_nxt    = sat32({{COORD_W{x_min_r[COORD_W-1]}}, x_min_r} + prod_r);
        state_nxt = S_CI_ADD;
      end
      S_CI_ADD: begin
        // prod_r holds col * y_step; z starts at c.
        ci_nxt    = sat32({{COORD_W{y_min_r[COORD_W-1]}}, y_min_r} + prod_r);
        zi_nxt    = sat32({{COORD_W{y_min_r[COORD_W-1]}}, y_min_r} + prod_r);
        zr_nxt    = cr_r;
        state_nxt = S_RR;
      end
      S_RR: begin
        state_nxt = S_II;
      end
      S_II: begin
        sqr_nxt   = prod_r;
        state_nxt = S_RI;
      end
      S_RI: begin
        // Both squares are at most 2^62, so neither sum nor difference wraps.
        mag_nxt   = sqr_r + prod_r;
        diff_nxt  = sqr_r - prod_r;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // prod_r holds zr*zi here; hold it while a finished result waits.
        prod_nxt = prod_r;
        if (keep_going) begin
          zr_nxt    = sat32(nr_wide);
          zi_nxt    = sat32(ni_wide);
          count_nxt = count_r + 1'b1;
          state_nxt = S_RR;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      x_min_r     <= X_MIN_RST;
      y_min_r     <= Y_MIN_RST;
      x_step_r    <= X_STEP_RST;
      y_step_r    <= Y_STEP_RST;
      max_iter_r  <= MAX_ITER_RST;
      esc_thr_r   <= ESC_THR_RST;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      x_min_r     <= x_min_nxt;
      y_min_r     <= y_min_nxt;
      x_step_r    <= x_step_nxt;
      y_step_r    <= y_step_nxt;
      max_iter_r  <= max_iter_nxt;
      esc_thr_r   <= esc_thr_nxt;
      count_r     <= count_nxt;
    end
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    prod_r      <= prod_nxt;
    sqr_r       <= sqr_nxt;
    diff_r      <= diff_nxt;
    mag_r       <= mag_nxt;
    out_count_r <= out_count_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  // The running count never passes the cap while a pixel is in flight.
  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_r <= max_iter_r))
    else $error("iteration count passed max_iterations");

  // An accepted pixel beat always makes the engine busy on the next cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (in_stall && count_r == '0))
    else $error("engine not busy after a pixel beat");

  // A freshly parked result never reports more iterations than the cap.
  a_result_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !keep_going && slot_free) |=>
      (out_valid_r && out_count_r <= max_iter_r && state_r == S_IDLE))
    else $error("result count above max_iterations");

endmodule

/* tb/tb_mandelbrot_escape_time.sv */
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Self-checking bench for the escape-time pixel engine. A directed table
// walks the register extremes and the corner cases, and random register
// settings follow. Every pixel beat is checked against an expected count,
// hand-typed or from an in-bench fixed-point predictor, and echoed indexes.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time
  import mbet_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles let pass after the last result before the engine is treated as idle.
  localparam int SETTLE_CYCLES    = 8;
  // Length of the one long receiver hold-off that backs the engine up.
  localparam int HOLD_CYCLES      = 400;
  localparam int NUM_PHASES       = 12;
  localparam int ITEMS_PER_PHASE  = 158;
  localparam int NUM_PLAN_ROWS    = 46;
  localparam int MAX_REPORTS      = 10;

  // Handy Q4.28 values.
  localparam logic [31:0] Q_MINUS_TWO     = 32'hE000_0000;
  localparam logic [31:0] Q_MINUS_ONEHALF = 32'hE800_0000;
  localparam logic [31:0] Q_THREE_EIGHT   = 32'h3CCC_CCCD;
  localparam logic [31:0] Q_MOST_NEG      = 32'h8000_0000;
  localparam logic [31:0] Q_MOST_POS      = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   prow;
    logic [IDX_W-1:0]   pcol;
  } pixel_result_t;

  typedef enum logic {OP_CFG_WRITE, OP_PIXEL} plan_op_t;

  // One line of the directed plan. For a register write only reg_idx and
  // data matter. For a pixel, typed says whether count is written out by
  // hand; otherwise the predictor supplies the count.
  typedef struct packed {
    plan_op_t           op;
    cfg_idx_t           reg_idx;
    logic [31:0]        data;
    logic [IDX_W-1:0]   prow;
    logic [IDX_W-1:0]   pcol;
    logic               typed;
    logic [COUNT_W-1:0] count;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [IDX_W-1:0]   in_pixel_row;
  logic [IDX_W-1:0]   in_pixel_col;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] out_iteration_count;
  logic [IDX_W-1:0]   out_row;
  logic [IDX_W-1:0]   out_col;

  // Predictor copy of the register file.
  logic signed [31:0] frame_x0;
  logic signed [31:0] frame_y0;
  logic [30:0]        frame_dx;
  logic [30:0]        frame_dy;
  logic [COUNT_W-1:0] iter_cap;
  logic [THR_W-1:0]   esc_limit;

  // Results still owed by the engine, oldest first.
  pixel_result_t awaited_pixels[$];

  int  mismatches;
  int  results_seen;
  int  pixels_sent;
  int  capped_pixels;
  int  settings_used;
  int  max_count_seen;

  // Idling knobs shared with the receiver process. A chance of zero means
  // no idling at all; otherwise one cycle in N starts a burst.
  int  rx_chance;
  int  tx_chance;
  bit  hold_req;

  mandelbrot_escape_time DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_row        (in_pixel_row),
    .in_pixel_col        (in_pixel_col),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_iteration_count (out_iteration_count),
    .out_row             (out_row),
    .out_col             (out_col)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Saturate to the signed 32-bit coordinate range.
  function automatic longint clip_q428(input longint v);
    longint res;
    if (v > 64'sd2147483647) begin
      res = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      res = -64'sd2147483648;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Escape-time count of one pixel under the current register copy.
  function automatic logic [COUNT_W-1:0] escape_count(input logic [IDX_W-1:0] prow,
                                                      input logic [IDX_W-1:0] pcol);
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      nr;
    longint      ni;
    longint      ridx;
    longint      cidx;
    longint      step;
    logic [63:0] mag;
    int unsigned n;
    ridx = prow;
    cidx = pcol;
    // Indexes past the image edge map onto its last row or column.
    if (ridx >= IMAGE_SIZE) begin
      ridx = IMAGE_SIZE - 1;
    end
    if (cidx >= IMAGE_SIZE) begin
      cidx = IMAGE_SIZE - 1;
    end
    cr = frame_x0;
    step = frame_dx;
    cr = clip_q428(cr + ridx * step);
    ci = frame_y0;
    step = frame_dy;
    ci = clip_q428(ci + cidx * step);
    zr = cr;
    zi = ci;
    n = 0;
    forever begin
      if (n >= iter_cap) begin
        break;
      end
      // Exact squared magnitude, compared in whole units.
      mag = 64'(zr * zr) + 64'(zi * zi);
      if ((mag >> ESC_SHIFT) >= 64'(esc_limit)) begin
        break;
      end
      // Both parts come from the old z; the cross term carries the factor two.
      nr = clip_q428(((zr * zr - zi * zi) >>> FRACTION_BITS) + cr);
      ni = clip_q428(((zr * zi) >>> (FRACTION_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      n++;
    end
    return COUNT_W'(n);
  endfunction

  // Write one register and mirror it into the predictor. Only called while
  // the engine is idle.
  task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_MIN:    frame_x0  = value;
      CFG_Y_MIN:    frame_y0  = value;
      CFG_X_STEP:   frame_dx  = value[30:0];
      CFG_Y_STEP:   frame_dy  = value[30:0];
      CFG_MAX_ITER: iter_cap  = value[COUNT_W-1:0];
      CFG_ESC_THR:  esc_limit = value[THR_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel beat and hold it until the engine takes it.
  task automatic offer_pixel(input logic [IDX_W-1:0] prow, input logic [IDX_W-1:0] pcol,
                             input logic typed, input logic [COUNT_W-1:0] typed_count);
    pixel_result_t expected;
    logic [COUNT_W-1:0] predicted;
    in_valid     <= 1'b1;
    in_pixel_row <= prow;
    in_pixel_col <= pcol;
    do @(posedge clk); while (in_stall);
    predicted      = escape_count(prow, pcol);
    expected.count = typed ? typed_count : predicted;
    expected.prow  = prow;
    expected.pcol  = pcol;
    if (predicted == iter_cap && predicted != 0) begin
      capped_pixels++;
    end
    awaited_pixels.push_back(expected);
    pixels_sent++;
  endtask

  task automatic sender_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending and wait until every owed result has come back, plus
  // SETTLE_CYCLES of settling so that the engine has surely gone idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Directed plan. Hand-typed counts are those that follow at once from the
  // registers: an escape on the very first test, a zero cap, a zero
  // threshold, or a cap of one around the origin.
  plan_row_t directed_plan [NUM_PLAN_ROWS] = '{
    // Reset values: the grid corners lie at about 2+2i in magnitude.
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd0,   9'd0,   1'b1, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd511, 9'd511, 1'b1, 20'd0},
    // A zero threshold escapes before the first iteration.
    '{OP_CFG_WRITE, CFG_ESC_THR,  32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd300, 9'd200, 1'b1, 20'd0},
    // A zero cap stops before the first iteration as well.
    '{OP_CFG_WRITE, CFG_ESC_THR,  32'd15,          9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_MAX_ITER, 32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd256, 9'd256, 1'b1, 20'd0},
    // Next to the origin with a cap of one the count is one.
    '{OP_CFG_WRITE, CFG_MAX_ITER, 32'd1,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd256, 9'd256, 1'b1, 20'd1},
    // Largest cap, far-out coordinates so that the pixels still escape.
    '{OP_CFG_WRITE, CFG_MAX_ITER, 32'hFFFF_FFFF,   9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_X_MIN,    Q_MOST_NEG,      9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd0,   9'd0,   1'b1, 20'd0},
    // Largest step: row 511 saturates the real part high.
    '{OP_CFG_WRITE, CFG_X_STEP,   Q_MOST_POS,      9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd511, 9'd0,   1'b1, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd1,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_MIN,    Q_MOST_POS,      9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_STEP,   32'hFFFF_FFFF,   9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd0,   9'd511, 1'b1, 20'd0},
    // c = 3.8 on the real axis: the first update overflows high.
    '{OP_CFG_WRITE, CFG_X_MIN,    Q_THREE_EIGHT,   9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_X_STEP,   32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_MIN,    32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_STEP,   32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd77,  9'd300, 1'b0, 20'd0},
    // c = 3.8i: the real part of the first update overflows low.
    '{OP_CFG_WRITE, CFG_X_MIN,    32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_MIN,    Q_THREE_EIGHT,   9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd400, 9'd9,   1'b0, 20'd0},
    // The classic frame: -2..1 by -1.5..1.5, a modest cap, threshold 4.
    '{OP_CFG_WRITE, CFG_X_MIN,    Q_MINUS_TWO,     9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_MIN,    Q_MINUS_ONEHALF, 9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_X_STEP,   32'h0018_0000,   9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_Y_STEP,   32'h0018_0000,   9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_MAX_ITER, 32'd40,          9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_CFG_WRITE, CFG_ESC_THR,  32'd4,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd511, 9'd511, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd340, 9'd256, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd170, 9'd256, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd100, 9'd300, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd255, 9'd170, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd350, 9'd350, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd128, 9'd383, 1'b0, 20'd0},
    // Threshold one with the same frame.
    '{OP_CFG_WRITE, CFG_ESC_THR,  32'd1,           9'd0,   9'd0,   1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd300, 9'd300, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd340, 9'd200, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd210, 9'd330, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd85,  9'd427, 1'b0, 20'd0},
    '{OP_PIXEL,     CFG_X_MIN,    32'd0,           9'd510, 9'd1,   1'b0, 20'd0}
  };

  // Result monitor. Sampling at the rising edge sees the values that the
  // engine saw, since every driver here updates through nonblocking writes.
  always @(posedge clk) begin : pixel_result_check
    pixel_result_t got;
    pixel_result_t expected;
    if (rst_n && out_valid && !out_stall) begin
      got.count = out_iteration_count;
      got.prow  = out_row;
      got.pcol  = out_col;
      results_seen++;
      if (int'(got.count) > max_count_seen) begin
        max_count_seen = int'(got.count);
      end
      if (awaited_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result beat count %0d row %0d col %0d",
                   $realtime, got.count, got.prow, got.pcol);
        end
      end else begin
        expected = awaited_pixels.pop_front();
        if (got != expected) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: pixel (%0d,%0d) expected count %0d row %0d col %0d,",
                     $realtime, expected.prow, expected.pcol, expected.count,
                     expected.prow, expected.pcol);
            $display("    got count %0d row %0d col %0d",
                     got.count, got.prow, got.pcol);
          end
        end
      end
    end
  end

  // Receiver. It stalls in random bursts, or, once on request, holds off for
  // a long stretch so that the engine backs up and stalls its input.
  initial begin : result_receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk);
        end
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_chance != 0 && $urandom_range(1, rx_chance) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Main stimulus: reset, the directed plan, then random register settings,
  // each followed by a stream of random pixels.
  initial begin : stimulus
    cfg_idx_t    order [6];
    cfg_idx_t    tmp_idx;
    logic [31:0] reg_val [6];
    int          phase;
    int          k;
    int          j;
    int          style;
    logic [IDX_W-1:0] prow;
    logic [IDX_W-1:0] pcol;

    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_X_MIN;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_pixel_row <= '0;
    in_pixel_col <= '0;
    hold_req     = 1'b0;
    rx_chance    = 4;
    tx_chance    = 3;
    mismatches     = 0;
    results_seen   = 0;
    pixels_sent    = 0;
    capped_pixels  = 0;
    settings_used  = 1;
    max_count_seen = 0;
    frame_x0  = X_MIN_RST;
    frame_y0  = Y_MIN_RST;
    frame_dx  = X_STEP_RST;
    frame_dy  = Y_STEP_RST;
    iter_cap  = MAX_ITER_RST;
    esc_limit = ESC_THR_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan. Register writes wait for the engine to drain first.
    for (k = 0; k < NUM_PLAN_ROWS; k++) begin
      if (directed_plan[k].op == OP_CFG_WRITE) begin
        drain_results();
        write_register(directed_plan[k].reg_idx, directed_plan[k].data);
        settings_used++;
      end else begin
        offer_pixel(directed_plan[k].prow, directed_plan[k].pcol,
                    directed_plan[k].typed, directed_plan[k].count);
        if ($urandom_range(1, tx_chance) == 1) begin
          sender_gap($urandom_range(1, 13));
        end
      end
    end

    // Random part. Most settings frame the interesting region of the plane;
    // some are drawn from the full register ranges. The last phase runs
    // with no idling on either side.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      style = $urandom_range(0, 3);
      if (style == 0) begin
        reg_val[CFG_X_MIN]  = $urandom;
        reg_val[CFG_Y_MIN]  = $urandom;
        reg_val[CFG_X_STEP] = $urandom;
        reg_val[CFG_Y_STEP] = $urandom;
      end else begin
        reg_val[CFG_X_MIN]  = 32'(-671088640 + int'($urandom_range(0, 536870912)));
        reg_val[CFG_Y_MIN]  = 32'(-536870912 + int'($urandom_range(0, 469762048)));
        reg_val[CFG_X_STEP] = $urandom_range(1 << 17, 1 << 21);
        reg_val[CFG_Y_STEP] = $urandom_range(1 << 17, 1 << 21);
      end
      // One deeper phase with a larger cap; elsewhere the cap stays small
      // so that pixels inside the set do not dominate the run time.
      if (phase == 3) begin
        reg_val[CFG_MAX_ITER] = $urandom_range(100, 255);
      end else begin
        reg_val[CFG_MAX_ITER] = $urandom_range(1, 48);
      end
      reg_val[CFG_ESC_THR] = ($urandom_range(0, 1) == 1) ? 32'd4 : $urandom_range(1, 15);

      order = '{CFG_X_MIN, CFG_Y_MIN, CFG_X_STEP, CFG_Y_STEP, CFG_MAX_ITER, CFG_ESC_THR};
      for (j = 5; j > 0; j--) begin
        style = $urandom_range(0, j);
        tmp_idx = order[j];
        order[j] = order[style];
        order[style] = tmp_idx;
      end
      for (j = 0; j < 6; j++) begin
        write_register(order[j], reg_val[order[j]]);
      end
      settings_used++;

      if (phase == NUM_PHASES - 1) begin
        rx_chance = 0;
        tx_chance = 0;
      end else begin
        rx_chance = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        tx_chance = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      end

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Long receiver hold-off while pixels keep coming.
        if (phase == 1 && k == 20) begin
          hold_req = 1'b1;
        end
        // Sender pauses until everything owed has come back.
        if (phase == 2 && k == 60) begin
          drain_results();
        end
        prow = $urandom_range(0, 511);
        pcol = $urandom_range(0, 511);
        if ($urandom_range(0, 15) == 0) begin
          prow = ($urandom_range(0, 1) == 1) ? 9'd511 : 9'd0;
          pcol = ($urandom_range(0, 1) == 1) ? 9'd511 : 9'd0;
        end
        offer_pixel(prow, pcol, 1'b0, '0);
        if (tx_chance != 0 && $urandom_range(1, tx_chance) == 1) begin
          sender_gap($urandom_range(1, 13));
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Checked %0d results for %0d pixel beats under %0d register settings.",
             results_seen, pixels_sent, settings_used);
    $display("Predicted %0d pixels to run to the cap; largest count seen was %0d.",
             capped_pixels, max_count_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
